[rtl/sxt_pkg.sv]
// Package: token codes, character constants and shared types of the S-expression tokenizer.
`timescale 1ns / 1ps

package sxt_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam logic [7:0] MaxSymLenReset = 8'd63;

  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChQuote  = 8'h27;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] ChF      = 8'h66;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChTab    = 8'h09;

  typedef enum logic [3:0] {
    KindLParen  = 4'd0,
    KindRParen  = 4'd1,
    KindQuote   = 4'd2,
    KindEmpty   = 4'd3,
    KindTrue    = 4'd4,
    KindFalse   = 4'd5,
    KindSymChar = 4'd6,
    KindSymEnd  = 4'd7,
    KindBadHash = 4'd8,
    KindTooLong = 4'd9
  } kind_e;

  typedef enum logic [2:0] {
    ModeIdle = 3'd0,
    ModeOpen = 3'd1,
    ModeHash = 3'd2,
    ModeHlet = 3'd3,
    ModeSym  = 3'd4,
    ModeSkip = 3'd5
  } mode_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
    logic [7:0] idx;
  } token_t;

  // One queue entry: all tokens caused by one input item (one or two).
  typedef struct packed {
    token_t tok0;
    token_t tok1;
    logic   two;
  } entry_t;

endpackage

[rtl/sxt_front.sv]
// Front end: accepts bytes, runs the lexer state machine and queues the tokens of each byte.
`timescale 1ns / 1ps

module sxt_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [7:0]      cfg_wdata_i,
  input  logic            push,
  output logic            full,
  input  logic [7:0]      in_byte_i,
  input  logic            end_of_input_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output sxt_pkg::entry_t q_entry_o
);
  import sxt_pkg::*;

  mode_e      mode_q, mode_d;
  logic [7:0] count_q, count_d;
  logic       letter_q, letter_d;
  logic [7:0] max_len_q;
  logic       accept;

  logic       is_space, is_delim, is_tf;
  logic       sym_fits;
  token_t     sym_tok;
  kind_e      bool_kind;

  // what the byte does when handled as from idle
  logic       idle_valid;
  token_t     idle_tok;
  mode_e      idle_mode;
  logic [7:0] idle_count;

  token_t     pre_tok;
  logic       pre_valid;
  logic       use_idle;

  assign accept    = push && !q_full_i;
  assign full      = q_full_i;
  assign is_space  = (in_byte_i == ChSpace) || (in_byte_i == ChNl) || (in_byte_i == ChTab);
  assign is_delim  = is_space || (in_byte_i == ChLParen) || (in_byte_i == ChRParen);
  assign is_tf     = (in_byte_i == ChT) || (in_byte_i == ChF);
  assign bool_kind = letter_q ? KindTrue : KindFalse;
  assign sym_fits  = count_q < max_len_q;

  always_comb begin
    sym_tok = '{kind: KindTooLong, ch: 8'd0, idx: 8'd0};
    if (sym_fits) begin
      sym_tok = '{kind: KindSymChar, ch: in_byte_i, idx: count_q};
    end
  end

  always_comb begin
    idle_valid = 1'b0;
    idle_tok   = '{kind: KindRParen, ch: 8'd0, idx: 8'd0};
    idle_mode  = ModeIdle;
    idle_count = count_q;
    priority if (is_space) begin
      idle_valid = 1'b0;
    end else if (in_byte_i == ChRParen) begin
      idle_valid = 1'b1;
    end else if (in_byte_i == ChQuote) begin
      idle_valid    = 1'b1;
      idle_tok.kind = KindQuote;
    end else if (in_byte_i == ChLParen) begin
      idle_mode = ModeOpen;
    end else if (in_byte_i == ChHash) begin
      idle_mode = ModeHash;
    end else begin
      idle_valid = 1'b1;
      // new symbol: count starts at zero, so it fits unless the limit is zero
      if (max_len_q != 8'd0) begin
        idle_tok   = '{kind: KindSymChar, ch: in_byte_i, idx: 8'd0};
        idle_mode  = ModeSym;
        idle_count = 8'd1;
      end else begin
        idle_tok.kind = KindTooLong;
        idle_mode     = ModeSkip;
        idle_count    = 8'd0;
      end
    end
  end

  // next state
  always_comb begin
    mode_d   = mode_q;
    count_d  = count_q;
    letter_d = letter_q;
    if (end_of_input_i) begin
      mode_d  = ModeIdle;
      count_d = 8'd0;
    end else begin
      unique case (mode_q)
        ModeOpen: begin
          if (in_byte_i == ChRParen) begin
            mode_d = ModeIdle;
          end else if (!is_space) begin
            mode_d  = idle_mode;
            count_d = idle_count;
          end
        end
        ModeHash: begin
          mode_d = is_tf ? ModeHlet : ModeIdle;
          if (is_tf) begin
            letter_d = (in_byte_i == ChT);
          end
        end
        ModeHlet: begin
          mode_d = ModeIdle;
          if (is_delim) begin
            mode_d  = idle_mode;
            count_d = idle_count;
          end
        end
        ModeSym: begin
          if (is_delim) begin
            mode_d  = idle_mode;
            count_d = idle_count;
          end else if (sym_fits) begin
            count_d = count_q + 8'd1;
          end else begin
            mode_d  = ModeSkip;
            count_d = 8'd0;
          end
        end
        ModeSkip: begin
          if (is_delim) begin
            mode_d  = idle_mode;
            count_d = idle_count;
          end
        end
        default: begin
          mode_d  = idle_mode;
          count_d = idle_count;
        end
      endcase
    end
  end

  // tokens: an optional first token, then possibly the byte handled as from idle
  always_comb begin
    pre_valid = 1'b0;
    pre_tok   = '{kind: KindLParen, ch: 8'd0, idx: 8'd0};
    use_idle  = 1'b0;
    if (end_of_input_i) begin
      unique case (mode_q)
        ModeOpen: pre_valid = 1'b1;
        ModeHash: begin
          pre_valid    = 1'b1;
          pre_tok.kind = KindBadHash;
        end
        ModeHlet: begin
          pre_valid    = 1'b1;
          pre_tok.kind = bool_kind;
        end
        ModeSym: begin
          pre_valid = 1'b1;
          pre_tok   = '{kind: KindSymEnd, ch: 8'd0, idx: count_q};
        end
        default: pre_valid = 1'b0;
      endcase
    end else begin
      unique case (mode_q)
        ModeOpen: begin
          if (in_byte_i == ChRParen) begin
            pre_valid    = 1'b1;
            pre_tok.kind = KindEmpty;
          end else if (!is_space) begin
            pre_valid = 1'b1;
            use_idle  = 1'b1;
          end
        end
        ModeHash: begin
          if (!is_tf) begin
            pre_valid    = 1'b1;
            pre_tok.kind = KindBadHash;
          end
        end
        ModeHlet: begin
          pre_valid    = 1'b1;
          pre_tok.kind = is_delim ? bool_kind : KindBadHash;
          use_idle     = is_delim;
        end
        ModeSym: begin
          pre_valid = 1'b1;
          if (is_delim) begin
            pre_tok  = '{kind: KindSymEnd, ch: 8'd0, idx: count_q};
            use_idle = 1'b1;
          end else begin
            pre_tok = sym_tok;
          end
        end
        ModeSkip: use_idle = is_delim;
        default:  use_idle = 1'b1;
      endcase
    end
  end

  always_comb begin
    q_entry_o.tok0 = pre_tok;
    q_entry_o.tok1 = idle_tok;
    q_entry_o.two  = pre_valid && use_idle && idle_valid;
    if (!pre_valid) begin
      q_entry_o.tok0 = idle_tok;
    end
    q_push_o = accept && (pre_valid || (use_idle && idle_valid));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeIdle;
      count_q   <= 8'd0;
      letter_q  <= 1'b0;
      max_len_q <= MaxSymLenReset;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      if (accept) begin
        mode_q   <= mode_d;
        count_q  <= count_d;
        letter_q <= letter_d;
      end
    end
  end

endmodule

[rtl/sxt_fifo.sv]
// Short queue of token entries between front end and back end.
`timescale 1ns / 1ps

module sxt_fifo #(
  parameter int unsigned Depth = sxt_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sxt_pkg::entry_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output sxt_pkg::entry_t rdata_o
);
  import sxt_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

[rtl/sxt_back.sv]
// Back end: splits queued entries into single tokens and holds them in the output register.
`timescale 1ns / 1ps

module sxt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  sxt_pkg::entry_t q_entry_i,
  output logic            q_pop_o,
  output logic            empty,
  input  logic            pop,
  output logic [3:0]      token_kind_o,
  output logic [7:0]      symbol_char_o,
  output logic [7:0]      char_index_o,
  output logic            last_of_run_o
);
  import sxt_pkg::*;

  logic   out_valid_q, out_valid_d;
  token_t out_tok_q, out_tok_d;
  logic   out_last_q, out_last_d;
  logic   sel_q, sel_d;   // which token of the head entry goes next
  logic   load;

  assign load = !out_valid_q || pop;

  always_comb begin
    out_valid_d = out_valid_q;
    out_tok_d   = out_tok_q;
    out_last_d  = out_last_q;
    sel_d       = sel_q;
    q_pop_o     = 1'b0;
    if (load) begin
      out_valid_d = !q_empty_i;
      if (!q_empty_i) begin
        out_tok_d  = sel_q ? q_entry_i.tok1 : q_entry_i.tok0;
        out_last_d = sel_q || !q_entry_i.two;
        q_pop_o    = out_last_d;
        sel_d      = !out_last_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_tok_q  <= out_tok_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sel_q       <= sel_d;
    end
  end

  assign empty         = !out_valid_q;
  assign token_kind_o  = out_tok_q.kind;
  assign symbol_char_o = out_tok_q.ch;
  assign char_index_o  = out_tok_q.idx;
  assign last_of_run_o = out_last_q;

endmodule

[rtl/sexpr_tokenizer.sv]
// Top level of the S-expression tokenizer: front end, entry queue and back end.
//
//  Channel  | Handshake          | Data
//  ---------+--------------------+--------------------------------------------------
//  input    | push / full        | in_byte_i, end_of_input_i
//  result   | pop / empty        | token_kind_o, symbol_char_o, char_index_o,
//           |                    | last_of_run_o
//  config   | cfg_we_i           | cfg_wdata_i (max_symbol_length)
//
// One byte is taken per cycle while full is low; each byte is classified in the cycle it
// is taken and its one or two tokens, if any, are queued as one entry. Tokens leave at
// one per cycle while pop is held, from the output register, so a byte that gives
// two tokens gives two results. Tokens pass the queue, then the output register.
// After reset the lexer is idle, the queue empty and the symbol limit 63.
// A stalled result side fills the queue; full then rises and input stalls.
`timescale 1ns / 1ps

module sexpr_tokenizer #(
  parameter int unsigned QueueDepth = sxt_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  output logic       empty,
  input  logic       pop,
  output logic [3:0] token_kind_o,
  output logic [7:0] symbol_char_o,
  output logic [7:0] char_index_o,
  output logic       last_of_run_o
);
  import sxt_pkg::*;

  logic   q_push, q_full, q_pop, q_empty;
  entry_t q_wdata, q_rdata;

  sxt_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .in_byte_i      (in_byte_i),
    .end_of_input_i (end_of_input_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_entry_o      (q_wdata)
  );

  sxt_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_rdata)
  );

  sxt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_entry_i     (q_rdata),
    .q_pop_o       (q_pop),
    .empty         (empty),
    .pop           (pop),
    .token_kind_o  (token_kind_o),
    .symbol_char_o (symbol_char_o),
    .char_index_o  (char_index_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
